// ===== src/assert_macros.svh =====
// Assertion macros shared by the cache lookup RTL.
// They expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SACL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sacl_pkg.sv =====
// Shared types and constants of the set-associative cache lookup block.
// No dependencies; the top level, the controller and the datapath import it.
`default_nettype none

package sacl_pkg;

  localparam int ADDR_W    = 32;
  localparam int STAMP_W   = 32;
  localparam int CFG_W     = 4;
  localparam int SET_OUT_W = 8;
  localparam int WAY_OUT_W = 3;
  localparam int SET8_DEPTH = 2 ** SET_OUT_W;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [CFG_W-1:0] OBITS_MAX = 4'd12;
  localparam logic [CFG_W-1:0] SBITS_MAX = 4'd8;

  localparam logic [CFG_W-1:0] BLOCK_OFFSET_RST = 4'd4;
  localparam logic [CFG_W-1:0] SET_INDEX_RST    = 4'd6;
  localparam logic [CFG_W-1:0] WAYS_RST         = 4'd4;

  typedef enum logic [1:0] {
    REG_BLOCK_OFFSET = 2'd0,
    REG_SET_INDEX    = 2'd1,
    REG_WAYS         = 2'd2,
    REG_NONE         = 2'd3
  } sacl_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] block_offset_bits;
    logic [CFG_W-1:0] set_index_bits;
    logic [CFG_W-1:0] ways_in_use;
  } sacl_cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_CMP,
    ST_UPD
  } sacl_state_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic decode;
    logic compare;
    logic commit;
  } sacl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } sacl_status_t;

endpackage

`default_nettype wire

// ===== src/set_assoc_cache_lru_lookup.sv =====
// Set-associative cache tag lookup with least-recently-used replacement.
// Input channel: in_valid / in_stall with in_address, one byte address per
// transfer. Result channel: out_valid / out_stall with out_hit, out_way and
// out_set_index, exactly one result transfer per input transfer, in order.
// Configuration: APB-style port, block_offset_bits at 0x0, set_index_bits at
// 0x4, ways_in_use at 0x8; pready is always high; write only while idle.
// Each access runs through accept, row read from the tag and stamp RAMs,
// compare of all ways, then row write-back, which also loads the result
// register. A new address is taken only once the previous access has written
// its row back; the single read-modify-write of a set row per access sets this.
// After reset a clearing pass zeroes the valid bits and stamps of all set
// rows, one set row per cycle, and in_stall stays high throughout; the
// configuration port works during the pass. Tags are not cleared.
// A result that the receiver stalls waits in the output register while the
// next access is read and compared; its write-back waits until that result
// has been transferred.
`default_nettype none

module set_assoc_cache_lru_lookup #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sacl_pkg::ADDR_W-1:0]   in_address,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_hit,
  output logic [sacl_pkg::WAY_OUT_W-1:0]     out_way,
  output logic [sacl_pkg::SET_OUT_W-1:0]     out_set_index,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sacl_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sacl_pkg::PDATA_W-1:0]  pwdata,
  output logic      [sacl_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);

  import sacl_pkg::*;

  // Configuration registers; the word address sits above the byte lanes.
  sacl_cfg_t    cfg_r;
  sacl_reg_t    reg_sel;
  logic         cfg_wr;

  assign reg_sel = sacl_reg_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_offset_bits <= BLOCK_OFFSET_RST;
      cfg_r.set_index_bits    <= SET_INDEX_RST;
      cfg_r.ways_in_use       <= WAYS_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BLOCK_OFFSET: cfg_r.block_offset_bits <= pwdata[CFG_W-1:0];
        REG_SET_INDEX:    cfg_r.set_index_bits    <= pwdata[CFG_W-1:0];
        REG_WAYS:         cfg_r.ways_in_use       <= pwdata[CFG_W-1:0];
        default:          cfg_r                   <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLOCK_OFFSET: prdata = PDATA_W'(cfg_r.block_offset_bits);
      REG_SET_INDEX:    prdata = PDATA_W'(cfg_r.set_index_bits);
      REG_WAYS:         prdata = PDATA_W'(cfg_r.ways_in_use);
      default:          prdata = '0;
    endcase
  end

  // The controller sequences each access; the datapath holds all rows.
  sacl_cmd_t    cmd;
  sacl_status_t status;

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sacl_dp #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg_r),
    .in_address    (in_address),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_way       (out_way),
    .out_set_index (out_set_index)
  );

endmodule

`default_nettype wire

// ===== src/sacl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for the tag rows and the valid/stamp rows.
`default_nettype none

module sacl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/sacl_ctrl.sv =====
// Sequencer of the cache lookup: clearing pass, then read, compare, update.
// Depends on sacl_pkg for the state, command and status types.
`default_nettype none

module sacl_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire sacl_pkg::sacl_status_t status,
  output sacl_pkg::sacl_cmd_t         cmd
);

  import sacl_pkg::*;

  sacl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (status.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_LOOK;
      ST_LOOK:  state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_UPD;
      ST_UPD:   if (status.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_LOOK: cmd.decode = 1'b1;
      ST_CMP:  cmd.compare = 1'b1;
      ST_UPD:  cmd.commit = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/sacl_dp.sv =====
// Datapath of the cache lookup: address split, tag and stamp rows, hit and
// LRU selection, row write-back and the result register. Uses sacl_pkg,
// sacl_ram and the assertion macros.
`default_nettype none
`include "assert_macros.svh"

module sacl_dp #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sacl_pkg::sacl_cmd_t        cmd,
  output sacl_pkg::sacl_status_t          status,
  input  wire sacl_pkg::sacl_cfg_t        cfg,
  input  wire logic [sacl_pkg::ADDR_W-1:0] in_address,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic [sacl_pkg::WAY_OUT_W-1:0]  out_way,
  output logic [sacl_pkg::SET_OUT_W-1:0]  out_set_index
);

  import sacl_pkg::*;

  localparam int SET_W      = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W      = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W      = $clog2(MAX_WAYS + 1);
  localparam int WIDE_W     = CFG_W + 1;
  localparam int META_W     = STAMP_W + 1;
  localparam int TAG_ROW_W  = ADDR_W * MAX_WAYS;
  localparam int META_ROW_W = META_W * MAX_WAYS;

  // Registers.
  logic [ADDR_W-1:0]    addr_r;
  logic [SET_W-1:0]     set_r;
  logic [ADDR_W-1:0]    tag_r;
  logic [STAMP_W-1:0]   stamp_r;
  logic [SET_W-1:0]     clr_cnt_r;
  logic                 hit_any_r;
  logic [WAY_W-1:0]     hit_idx_r;
  logic [CNT_W-1:0]     ways_r;
  logic [MAX_WAYS-1:0]  lt_r [MAX_WAYS];
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [WAY_OUT_W-1:0] out_way_r;
  logic [SET_OUT_W-1:0] out_set_r;

  // Address split.
  logic [CFG_W-1:0]     obits, sbits;
  logic [ADDR_W-1:0]    block, tag_d;
  logic [SET_OUT_W-1:0] set_mask, set8;
  logic [SET_W-1:0]     set_d;
  logic [SET_W-1:0]     fold_tab [SET8_DEPTH];

  for (genvar g = 0; g < SET8_DEPTH; g++) begin : g_fold
    assign fold_tab[g] = SET_W'(g % MAX_SETS);
  end

  always_comb begin
    obits    = (cfg.block_offset_bits > OBITS_MAX) ? OBITS_MAX : cfg.block_offset_bits;
    sbits    = (cfg.set_index_bits > SBITS_MAX) ? SBITS_MAX : cfg.set_index_bits;
    block    = addr_r >> obits;
    set_mask = SET_OUT_W'(((SET_OUT_W + 1)'(1) << sbits) - (SET_OUT_W + 1)'(1));
    set8     = block[SET_OUT_W-1:0] & set_mask;
    tag_d    = block >> sbits;
    set_d    = fold_tab[set8];
  end

  // Row storage.
  logic [TAG_ROW_W-1:0]  tag_rd, tag_wr;
  logic [META_ROW_W-1:0] meta_rd, meta_wr, meta_wdata;
  logic [SET_W-1:0]      meta_waddr;
  logic                  meta_we;

  assign meta_we    = cmd.clear_wr | cmd.commit;
  assign meta_waddr = cmd.clear_wr ? clr_cnt_r : set_r;
  assign meta_wdata = cmd.clear_wr ? '0 : meta_wr;

  sacl_ram #(.WIDTH(TAG_ROW_W), .DEPTH(MAX_SETS)) u_tag_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (set_r),
    .wdata (tag_wr),
    .re    (cmd.decode),
    .raddr (set_d),
    .rdata (tag_rd)
  );

  sacl_ram #(.WIDTH(META_ROW_W), .DEPTH(MAX_SETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (cmd.decode),
    .raddr (set_d),
    .rdata (meta_rd)
  );

  // Compare stage: per-way hit and pairwise stamp order.
  logic [WIDE_W-1:0]   ways_wide;
  logic [CNT_W-1:0]    ways_eff;
  logic [STAMP_W-1:0]  stamp_a [MAX_WAYS];
  logic [MAX_WAYS-1:0] hit_vec;
  logic                hit_any;
  logic [WAY_W-1:0]    hit_idx;
  logic [MAX_WAYS-1:0] lt_nxt [MAX_WAYS];

  always_comb begin
    ways_wide = {1'b0, cfg.ways_in_use};
    if (ways_wide == '0) begin
      ways_wide = WIDE_W'(1);
    end else if (ways_wide > WIDE_W'(MAX_WAYS)) begin
      ways_wide = WIDE_W'(MAX_WAYS);
    end
    ways_eff = CNT_W'(ways_wide);

    for (int w = 0; w < MAX_WAYS; w++) begin
      stamp_a[w] = meta_rd[w*META_W +: STAMP_W];
      hit_vec[w] = meta_rd[w*META_W + STAMP_W] &&
                   (tag_rd[w*ADDR_W +: ADDR_W] == tag_r) &&
                   (CNT_W'(w) < ways_eff);
    end

    hit_any = |hit_vec;
    hit_idx = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_idx = WAY_W'(w);
    end

    for (int i = 0; i < MAX_WAYS; i++) begin
      for (int j = 0; j < MAX_WAYS; j++) begin
        lt_nxt[i][j] = stamp_a[i] < stamp_a[j];
      end
    end
  end

  // Update stage: the first way holding the smallest stamp wins on a miss.
  logic [MAX_WAYS-1:0] cand;
  logic [WAY_W-1:0]    min_idx, chosen;
  logic [STAMP_W-1:0]  stamp_nxt;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      cand[i] = CNT_W'(i) < ways_r;
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (j != i && CNT_W'(j) < ways_r) begin
          if (j < i) cand[i] = cand[i] & lt_r[i][j];
          else       cand[i] = cand[i] & ~lt_r[j][i];
        end
      end
    end

    min_idx = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (cand[w]) min_idx = WAY_W'(w);
    end

    chosen    = hit_any_r ? hit_idx_r : min_idx;
    stamp_nxt = stamp_r + STAMP_W'(1);
    tag_wr    = tag_rd;
    meta_wr   = meta_rd;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == chosen) begin
        if (!hit_any_r) tag_wr[w*ADDR_W +: ADDR_W] = tag_r;
        meta_wr[w*META_W +: META_W] = {1'b1, stamp_nxt};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r     <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_cnt_r <= clr_cnt_r + SET_W'(1);
      if (cmd.commit) begin
        stamp_r     <= stamp_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) addr_r <= in_address;
    if (cmd.decode) begin
      set_r <= set_d;
      tag_r <= tag_d;
    end
    if (cmd.compare) begin
      hit_any_r <= hit_any;
      hit_idx_r <= hit_idx;
      ways_r    <= ways_eff;
      lt_r      <= lt_nxt;
    end
    if (cmd.commit) begin
      out_hit_r <= hit_any_r;
      out_way_r <= WAY_OUT_W'(chosen);
      out_set_r <= SET_OUT_W'(set_r);
    end
  end

  assign status.clear_last = clr_cnt_r == SET_W'(MAX_SETS - 1);
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_way       = out_way_r;
  assign out_set_index = out_set_r;

  `SACL_ASSERT_NOW(a_chosen_in_range, cmd.commit, CNT_W'(chosen) < ways_r,
    "selected way lies beyond the ways in use")
  `SACL_ASSERT_NOW(a_commit_needs_room, cmd.commit, status.out_free,
    "row update while the result register is still held")
  `SACL_ASSERT_NEXT(a_result_follows, cmd.commit,
    out_valid_r && (out_set_r == SET_OUT_W'($past(set_r))),
    "result register does not show the set just updated")

endmodule

`default_nettype wire
